### src/ray_sphere_sky_shader_unit_macros.svh
// Assertion macros; clk and arst_n are taken from the module that uses them.
`ifndef RAY_SPHERE_SKY_SHADER_UNIT_MACROS_SVH
`define RAY_SPHERE_SKY_SHADER_UNIT_MACROS_SVH
// same-cycle implication
`define RSSS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define RSSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### src/rsss_pkg.sv
`default_nettype none
package rsss_pkg;
	localparam int FRAC_BITS = 16;
	localparam int MAX_WIDTH_DEF = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam int IDX_W = 12;
	localparam int DIR_W = 19;
	localparam int RAD_W = 18;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 19;
	localparam int PROD_W = IDX_W + 1 + DIR_W;
	localparam int MAG_W = DIR_W;
	localparam int SQ_W = 2 * (DIR_W - 1) + 1;
	localparam int A_W = SQ_W + 1;
	localparam int CZ2_W = SQ_W;
	localparam int C_W = CZ2_W + 1;
	localparam int AC_W = A_W + CZ2_W;
	localparam int ROOT_W = A_W / 2;
	localparam int NUM_W = MAG_W + FRAC_BITS;
	localparam int Q_W = FRAC_BITS + 1;

	localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPHERE_CZ = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPHERE_R = 3'd5;

	localparam logic signed [DIR_W-1:0] START_X_RST = -19'sd116508;
	localparam logic signed [DIR_W-1:0] START_Y_RST = 19'sd65472;
	localparam logic signed [DIR_W-1:0] STEP_X_RST = 19'sd364;
	localparam logic signed [DIR_W-1:0] STEP_Y_RST = -19'sd364;
	localparam logic signed [DIR_W-1:0] SPHERE_CZ_RST = -19'sd65536;
	localparam logic [RAD_W-1:0] SPHERE_R_RST = 18'd32768;

	typedef struct packed {
		logic valid;
		logic hit;
		logic neg;
	} sb_t;
endpackage
`default_nettype wire

### src/rsss_isqrt.sv
`default_nettype none
module rsss_isqrt (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire rsss_pkg::sb_t           sb_in,
	input  wire logic [rsss_pkg::A_W-1:0]    a_in,
	input  wire logic [rsss_pkg::MAG_W-1:0]  mag_in,
	output rsss_pkg::sb_t                sb_out,
	output logic [rsss_pkg::ROOT_W-1:0]  root_out,
	output logic [rsss_pkg::MAG_W-1:0]   mag_out
);
	import rsss_pkg::*;

	localparam int TW = A_W + 2;

	logic [A_W-1:0]    rem_i  [ROOT_W];
	logic [A_W-1:0]    rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_i [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [MAG_W-1:0]  mag_i  [ROOT_W];
	logic [MAG_W-1:0]  mag_s  [ROOT_W];
	sb_t               sb_i   [ROOT_W];
	sb_t               sb_s   [ROOT_W];

	// one root bit per stage, msb first
	for (genvar j = 0; j < ROOT_W; j++) begin : g_st
		localparam int I = ROOT_W - 1 - j;
		logic [TW-1:0] trial;
		logic          ge;

		if (j == 0) begin : g_first
			assign rem_i[j]  = a_in;
			assign root_i[j] = '0;
			assign mag_i[j]  = mag_in;
			assign sb_i[j]   = sb_in;
		end else begin : g_next
			assign rem_i[j]  = rem_s[j-1];
			assign root_i[j] = root_s[j-1];
			assign mag_i[j]  = mag_s[j-1];
			assign sb_i[j]   = sb_s[j-1];
		end

		assign trial = (TW'(root_i[j]) << (I + 1)) + (TW'(1) << (2 * I));
		assign ge    = TW'(rem_i[j]) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sb_s[j] <= '0;
			end else if (en) begin
				sb_s[j] <= sb_i[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= ge ? (rem_i[j] - trial[A_W-1:0]) : rem_i[j];
				root_s[j] <= ge ? (root_i[j] | (ROOT_W'(1) << I)) : root_i[j];
				mag_s[j]  <= mag_i[j];
			end
		end
	end

	assign sb_out   = sb_s[ROOT_W-1];
	assign root_out = root_s[ROOT_W-1];
	assign mag_out  = mag_s[ROOT_W-1];
endmodule
`default_nettype wire

### src/rsss_div.sv
`default_nettype none
module rsss_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire rsss_pkg::sb_t            sb_in,
	input  wire logic [rsss_pkg::NUM_W-1:0]  num_in,
	input  wire logic [rsss_pkg::ROOT_W-1:0] den_in,
	output rsss_pkg::sb_t                 sb_out,
	output logic [rsss_pkg::Q_W-1:0]      quot_out
);
	import rsss_pkg::*;

	logic [NUM_W-1:0]  rem_i [Q_W];
	logic [NUM_W-1:0]  rem_s [Q_W];
	logic [ROOT_W-1:0] den_i [Q_W];
	logic [ROOT_W-1:0] den_s [Q_W];
	logic [Q_W-1:0]    q_i   [Q_W];
	logic [Q_W-1:0]    q_s   [Q_W];
	sb_t               sb_i  [Q_W];
	sb_t               sb_s  [Q_W];

	// restoring division, one quotient bit per stage; quotient never exceeds Q_W bits
	for (genvar j = 0; j < Q_W; j++) begin : g_st
		localparam int K = Q_W - 1 - j;
		logic [NUM_W-1:0] dsh;
		logic             ge;

		if (j == 0) begin : g_first
			assign rem_i[j] = num_in;
			assign den_i[j] = den_in;
			assign q_i[j]   = '0;
			assign sb_i[j]  = sb_in;
		end else begin : g_next
			assign rem_i[j] = rem_s[j-1];
			assign den_i[j] = den_s[j-1];
			assign q_i[j]   = q_s[j-1];
			assign sb_i[j]  = sb_s[j-1];
		end

		assign dsh = NUM_W'(den_i[j]) << K;
		assign ge  = rem_i[j] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sb_s[j] <= '0;
			end else if (en) begin
				sb_s[j] <= sb_i[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? (rem_i[j] - dsh) : rem_i[j];
				den_s[j] <= den_i[j];
				q_s[j]   <= ge ? (q_i[j] | (Q_W'(1) << K)) : q_i[j];
			end
		end
	end

	assign sb_out   = sb_s[Q_W-1];
	assign quot_out = q_s[Q_W-1];
endmodule
`default_nettype wire

### src/ray_sphere_sky_shader_unit.sv
// Ray/sphere sky shader. Takes one pixel (column, row) per cycle when not stalled and
// returns one RGB item per pixel, in order. The work runs through 46 register stages: 8
// stages form the ray direction and test it against the sphere, 19 stages take the integer
// square root of |d|^2, 17 stages divide dy by |d|, and 2 stages form the colour bytes. The
// first stage loads at the edge that accepts the pixel. One global stall freezes the whole
// pipeline while the output register holds an item that has not been taken. Registers are
// written through a plain write port; write them only while no item is in flight.
`default_nettype none
module ray_sphere_sky_shader_unit #(
	parameter int MAX_WIDTH  = rsss_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rsss_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write_enable,
	input  wire logic [rsss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [rsss_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [rsss_pkg::IDX_W-1:0]        column,
	input  wire logic [rsss_pkg::IDX_W-1:0]        row,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [7:0]                             red,
	output logic [7:0]                             green,
	output logic [7:0]                             blue,
	output logic                                   sphere_hit
);
	import rsss_pkg::*;

	localparam logic [IDX_W-1:0] COL_LAST = IDX_W'(MAX_WIDTH - 1);
	localparam logic [IDX_W-1:0] ROW_LAST = IDX_W'(MAX_HEIGHT - 1);
	localparam int SUM_W = PROD_W + 1;
	localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'((2 ** (DIR_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_W'(2 ** (DIR_W - 1));
	localparam logic [Q_W-1:0] ONE = Q_W'(1) << FRAC_BITS;
	localparam int SCALE_SH = FRAC_BITS + 8;
	localparam int RED_SH = 2 * FRAC_BITS + 1;
	localparam int GRN_SH = 2 * FRAC_BITS;
	localparam int RX_W = FRAC_BITS + 2 + SCALE_SH;
	localparam int GX_W = FRAC_BITS + 4 + SCALE_SH;
	localparam int Y_W = 12;
	localparam int GP_W = Y_W + 13;
	localparam logic [GP_W-1:0] TENTH = GP_W'(6554);
	localparam int LO_W = 19;

	function automatic logic signed [DIR_W-1:0] sat_dir(input logic signed [SUM_W-1:0] v);
		logic signed [DIR_W-1:0] r;
		if (v > SUM_HI) r = SUM_HI[DIR_W-1:0];
		else if (v < SUM_LO) r = SUM_LO[DIR_W-1:0];
		else r = v[DIR_W-1:0];
		return r;
	endfunction

	function automatic logic [MAG_W-1:0] mag(input logic signed [DIR_W-1:0] v);
		return v[DIR_W-1] ? MAG_W'(-v) : MAG_W'(v);
	endfunction

	// configuration
	logic signed [DIR_W-1:0] start_x_q, start_y_q, step_x_q, step_y_q, sphere_cz_q;
	logic [RAD_W-1:0]        sphere_r_q;
	logic [CZ2_W-1:0]        cz2_q;
	logic [2*RAD_W-1:0]      r2_q;
	logic signed [C_W-1:0]   c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q   <= START_X_RST;
			start_y_q   <= START_Y_RST;
			step_x_q    <= STEP_X_RST;
			step_y_q    <= STEP_Y_RST;
			sphere_cz_q <= SPHERE_CZ_RST;
			sphere_r_q  <= SPHERE_R_RST;
		end else if (cfg_write_enable) begin
			unique case (cfg_index)
				REG_START_X:   start_x_q   <= cfg_data;
				REG_START_Y:   start_y_q   <= cfg_data;
				REG_STEP_X:    step_x_q    <= cfg_data;
				REG_STEP_Y:    step_y_q    <= cfg_data;
				REG_SPHERE_CZ: sphere_cz_q <= cfg_data;
				REG_SPHERE_R:  sphere_r_q  <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	logic [2*DIR_W-1:0] cz_sq;
	assign cz_sq = mag(sphere_cz_q) * mag(sphere_cz_q);

	always_ff @(posedge clk) begin
		cz2_q <= cz_sq[CZ2_W-1:0];
		r2_q  <= sphere_r_q * sphere_r_q;
		c_q   <= $signed({1'b0, cz2_q}) - $signed(C_W'(r2_q));
	end

	// pipeline control
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s45, v_s46;

	// s1: clamp, products
	logic [IDX_W-1:0]         col_c, row_c;
	logic signed [PROD_W-1:0] px_s1, py_s1;

	assign col_c = ({1'b0, column} >= (IDX_W + 1)'(MAX_WIDTH)) ? COL_LAST : column;
	assign row_c = ({1'b0, row} >= (IDX_W + 1)'(MAX_HEIGHT)) ? ROW_LAST : row;

	// s2: direction
	logic signed [SUM_W-1:0] sum_x, sum_y;
	logic signed [DIR_W-1:0] dx_s2, dy_s2;

	assign sum_x = $signed({px_s1[PROD_W-1], px_s1})
		+ $signed({{(SUM_W - DIR_W){start_x_q[DIR_W-1]}}, start_x_q});
	assign sum_y = $signed({py_s1[PROD_W-1], py_s1})
		+ $signed({{(SUM_W - DIR_W){start_y_q[DIR_W-1]}}, start_y_q});

	// s3: squares
	logic [2*MAG_W-1:0] sqx_full, sqy_full;
	logic [SQ_W-1:0]    sqx_s3, sqy_s3;
	logic [MAG_W-1:0]   mag_s3, mag_s4, mag_s5, mag_s6, mag_s7, mag_s8;
	logic               neg_s3, neg_s4, neg_s5, neg_s6, neg_s7, neg_s8;

	assign sqx_full = mag(dx_s2) * mag(dx_s2);
	assign sqy_full = mag(dy_s2) * mag(dy_s2);

	// s4: a = d.d
	logic [A_W-1:0] a_s4, a_s5, a_s6, a_s7, a_s8;

	// s5..s8: a*c against h*h
	logic [2*LO_W-1:0]          pp0_s5, pp1_s5, pp2_s5, pp3_s5;
	logic [2*LO_W-1:0]          pp0_s6, pp3_s6;
	logic [2*LO_W:0]            mid_s6;
	logic [AC_W-1:0]            ac_s7;
	logic                       cpos_s5, cpos_s6, cpos_s7;
	logic                       hit_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= $signed({1'b0, col_c}) * step_x_q;
			py_s1   <= $signed({1'b0, row_c}) * step_y_q;
			dx_s2   <= sat_dir(sum_x);
			dy_s2   <= sat_dir(sum_y);
			sqx_s3  <= sqx_full[SQ_W-1:0];
			sqy_s3  <= sqy_full[SQ_W-1:0];
			mag_s3  <= mag(dy_s2);
			neg_s3  <= dy_s2[DIR_W-1];
			a_s4    <= A_W'(sqx_s3) + A_W'(sqy_s3) + (A_W'(1) << GRN_SH);
			mag_s4  <= mag_s3;
			neg_s4  <= neg_s3;
			pp0_s5  <= (2*LO_W)'(a_s4[LO_W-1:0]) * (2*LO_W)'(c_q[LO_W-1:0]);
			pp1_s5  <= (2*LO_W)'(a_s4[LO_W-1:0]) * (2*LO_W)'(c_q[CZ2_W-1:LO_W]);
			pp2_s5  <= (2*LO_W)'(a_s4[A_W-1:LO_W]) * (2*LO_W)'(c_q[LO_W-1:0]);
			pp3_s5  <= (2*LO_W)'(a_s4[A_W-1:LO_W]) * (2*LO_W)'(c_q[CZ2_W-1:LO_W]);
			cpos_s5 <= c_q > 0;
			a_s5    <= a_s4;
			mag_s5  <= mag_s4;
			neg_s5  <= neg_s4;
			pp0_s6  <= pp0_s5;
			pp3_s6  <= pp3_s5;
			mid_s6  <= (2*LO_W + 1)'(pp1_s5) + (2*LO_W + 1)'(pp2_s5);
			cpos_s6 <= cpos_s5;
			a_s6    <= a_s5;
			mag_s6  <= mag_s5;
			neg_s6  <= neg_s5;
			ac_s7   <= AC_W'(pp0_s6) + (AC_W'(mid_s6) << LO_W) + (AC_W'(pp3_s6) << (2 * LO_W));
			cpos_s7 <= cpos_s6;
			a_s7    <= a_s6;
			mag_s7  <= mag_s6;
			neg_s7  <= neg_s6;
			hit_s8  <= !cpos_s7 || ((AC_W'(cz2_q) << GRN_SH) >= ac_s7);
			a_s8    <= a_s7;
			mag_s8  <= mag_s7;
			neg_s8  <= neg_s7;
		end
	end

	// length and dy/|d|
	sb_t               sb_sq, sb_dv;
	logic [ROOT_W-1:0] root_sq;
	logic [MAG_W-1:0]  mag_sq;
	logic [Q_W-1:0]    quot_dv;

	rsss_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.sb_in    ('{valid: v_s8, hit: hit_s8, neg: neg_s8}),
		.a_in     (a_s8),
		.mag_in   (mag_s8),
		.sb_out   (sb_sq),
		.root_out (root_sq),
		.mag_out  (mag_sq)
	);

	rsss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.sb_in    (sb_sq),
		.num_in   (NUM_W'(mag_sq) << FRAC_BITS),
		.den_in   (root_sq),
		.sb_out   (sb_dv),
		.quot_out (quot_dv)
	);

	// s45: gradient, red byte, green before /10
	logic [Q_W-1:0]  uy, t;
	logic [Q_W:0]    tsum;
	logic [Q_W:0]    rnum;
	logic [RX_W-1:0] rx, rq;
	logic [19:0]     gnum;
	logic [GX_W-1:0] gx;
	logic [7:0]      red_s45, red_s46, green_s46;
	logic [Y_W-1:0]  y_s45;
	logic            hit_s45, hit_s46;
	logic [GP_W-1:0] gp, gq;

	always_comb begin
		uy   = (quot_dv > ONE) ? ONE : quot_dv;
		tsum = sb_dv.neg ? ((Q_W + 1)'(ONE) - (Q_W + 1)'(uy)) : ((Q_W + 1)'(ONE) + (Q_W + 1)'(uy));
		t    = tsum[Q_W:1];
		rnum = ((Q_W + 1)'(ONE) << 1) - (Q_W + 1)'(t);
		rx   = (RX_W'(rnum) << SCALE_SH) - RX_W'(rnum);
		rq   = rx >> RED_SH;
		gnum = (20'(ONE) * 20'd10) - (20'(t) * 20'd3);
		gx   = (GX_W'(gnum) << SCALE_SH) - GX_W'(gnum);
		gp   = GP_W'(y_s45) * TENTH;
		gq   = gp >> 16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s45 <= 1'b0;
			v_s46 <= 1'b0;
		end else if (en) begin
			v_s45 <= sb_dv.valid;
			v_s46 <= v_s45;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s45   <= (rq > RX_W'(255)) ? 8'hFF : rq[7:0];
			y_s45     <= Y_W'(gx >> GRN_SH);
			hit_s45   <= sb_dv.hit;
			red_s46   <= hit_s45 ? 8'hFF : red_s45;
			green_s46 <= hit_s45 ? 8'h00 : ((gq > GP_W'(255)) ? 8'hFF : gq[7:0]);
			hit_s46   <= hit_s45;
		end
	end

	assign out_valid  = v_s46;
	assign red        = red_s46;
	assign green      = green_s46;
	assign blue       = hit_s46 ? 8'h00 : 8'hFF;
	assign sphere_hit = hit_s46;

`include "ray_sphere_sky_shader_unit_macros.svh"
	`RSSS_ASSERT_IMPL(a_hit_red, out_valid && sphere_hit, red == 8'hFF && green == 8'h00 && blue == 8'h00, "hit item not pure red")
	`RSSS_ASSERT_IMPL(a_sky_range, out_valid && !sphere_hit, blue == 8'hFF && red >= 8'd127, "sky item out of gradient range")
	`RSSS_ASSERT_IMPL(a_sky_order, out_valid && !sphere_hit, red <= green, "sky red above green")
	`RSSS_ASSERT_NEXT(a_stall_keeps, !en && v_s8, v_s8, "item lost during stall")
endmodule
`default_nettype wire

### verif/tb_ray_sphere_sky_shader_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_ray_sphere_sky_shader_unit;
	import rsss_pkg::*;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       hit;
	} pixel_t;

	typedef struct {
		logic [IDX_W-1:0] column;
		logic [IDX_W-1:0] row;
	} coord_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write_enable;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [IDX_W-1:0]      column;
	logic [IDX_W-1:0]      row;
	logic                  out_valid;
	logic                  out_ready;
	logic [7:0]            red;
	logic [7:0]            green;
	logic [7:0]            blue;
	logic                  sphere_hit;

	ray_sphere_sky_shader_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_enable(cfg_write_enable), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .column(column), .row(row),
		.out_valid(out_valid), .out_ready(out_ready),
		.red(red), .green(green), .blue(blue), .sphere_hit(sphere_hit)
	);

	// shadow copy of the view registers
	longint vx0, vy0, vsx, vsy, vcz;
	longint unsigned vrad;

	coord_t pixel_q[$];
	pixel_t colour_q[$];
	int     errors = 0;
	int     in_gap = 0;
	int     out_stall = 0;
	bit     steady = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int pick_gap();
		if (steady || $urandom_range(0, 9) < 6)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic longint clamp_dir(longint v);
		if (v > 262143)
			return 262143;
		if (v < -262144)
			return -262144;
		return v;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [7:0] chan_byte(longint unsigned num, longint unsigned den);
		longint unsigned b;
		b = (num * ((64'd256 << FRAC_BITS) - 1)) / (den << FRAC_BITS);
		return (b > 255) ? 8'd255 : b[7:0];
	endfunction

	function automatic pixel_t shade_pixel(coord_t p);
		longint          dx, dy, c;
		longint unsigned one, mx, my, a, cz2, len, uy, t;
		logic [127:0]    hh, ac;
		pixel_t          r;
		bit              hit;
		one = 64'd1 << FRAC_BITS;
		dx = clamp_dir(vx0 + longint'(p.column) * vsx);
		dy = clamp_dir(vy0 + longint'(p.row) * vsy);
		mx = (dx < 0) ? -dx : dx;
		my = (dy < 0) ? -dy : dy;
		a = mx * mx + my * my + one * one;
		cz2 = ((vcz < 0) ? -vcz : vcz) * ((vcz < 0) ? -vcz : vcz);
		c = longint'(cz2) - longint'(vrad * vrad);
		if (c <= 0) begin
			hit = 1;
		end else begin
			hh = 128'(cz2) * 128'(one * one);
			ac = 128'(a) * 128'(c);
			hit = (hh >= ac);
		end
		if (hit) begin
			r.red = 8'd255;
			r.green = 8'd0;
			r.blue = 8'd0;
			r.hit = 1'b1;
			return r;
		end
		len = floor_sqrt(a);
		uy = (my << FRAC_BITS) / len;
		if (uy > one)
			uy = one;
		t = (dy < 0) ? (one - uy) >> 1 : (one + uy) >> 1;
		r.red = chan_byte(2 * one - t, 2 * one);
		r.green = chan_byte(10 * one - 3 * t, 10 * one);
		r.blue = chan_byte(one, one);
		r.hit = 1'b0;
		return r;
	endfunction

	// pixel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			column <= '0;
			row <= '0;
		end else if (!in_valid || in_ready) begin
			coord_t p;
			if (in_valid) begin
				p.column = column;
				p.row = row;
				colour_q.push_back(shade_pixel(p));
			end
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (pixel_q.size() > 0) begin
				p = pixel_q.pop_front();
				column <= p.column;
				row <= p.row;
				in_valid <= 1'b1;
				in_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// colour monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			pixel_t e;
			if (out_valid && out_ready) begin
				if (colour_q.size() == 0) begin
					$error("unexpected item: red %0d green %0d blue %0d hit %0d",
						red, green, blue, sphere_hit);
					errors++;
				end else begin
					e = colour_q.pop_front();
					if (red !== e.red) begin
						$error("red: expected %0d, got %0d", e.red, red);
						errors++;
					end
					if (green !== e.green) begin
						$error("green: expected %0d, got %0d", e.green, green);
						errors++;
					end
					if (blue !== e.blue) begin
						$error("blue: expected %0d, got %0d", e.blue, blue);
						errors++;
					end
					if (sphere_hit !== e.hit) begin
						$error("sphere_hit: expected %0d, got %0d", e.hit, sphere_hit);
						errors++;
					end
				end
			end
			if (out_stall > 0) begin
				out_stall <= out_stall - 1;
				out_ready <= 1'b0;
			end else begin
				out_stall <= pick_gap();
				out_ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
		@(posedge clk);
		cfg_write_enable <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		case (idx)
			REG_START_X:   vx0 = val;
			REG_START_Y:   vy0 = val;
			REG_STEP_X:    vsx = val;
			REG_STEP_Y:    vsy = val;
			REG_SPHERE_CZ: vcz = val;
			REG_SPHERE_R:  vrad = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_write_enable <= 1'b0;
	endtask

	task automatic set_view(longint x0, longint y0, longint sx, longint sy, longint cz,
			longint rad);
		write_reg(REG_START_X, x0);
		write_reg(REG_START_Y, y0);
		write_reg(REG_STEP_X, sx);
		write_reg(REG_STEP_Y, sy);
		write_reg(REG_SPHERE_CZ, cz);
		write_reg(REG_SPHERE_R, rad);
		repeat (3) @(posedge clk);
	endtask

	task automatic drain();
		while (pixel_q.size() > 0 || in_valid || colour_q.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic add_pixel(int c, int r);
		coord_t p;
		p.column = c;
		p.row = r;
		pixel_q.push_back(p);
	endtask

	function automatic longint rand_dir(bit full);
		if (full)
			return longint'($urandom_range(0, 524287)) - 262144;
		return longint'($urandom_range(0, 131072)) - 65536;
	endfunction

	function automatic longint rand_step(bit full);
		if (full)
			return longint'($urandom_range(0, 524287)) - 262144;
		return longint'($urandom_range(0, 1600)) - 800;
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_write_enable = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		vx0 = START_X_RST;
		vy0 = START_Y_RST;
		vsx = STEP_X_RST;
		vsy = STEP_Y_RST;
		vcz = SPHERE_CZ_RST;
		vrad = SPHERE_R_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset view: corners, centre, edges
		add_pixel(0, 0);
		add_pixel(4095, 4095);
		add_pixel(0, 4095);
		add_pixel(4095, 0);
		add_pixel(320, 180);
		add_pixel(640, 0);
		add_pixel(0, 360);
		add_pixel(2730, 1365);
		add_pixel(1365, 2730);
		drain();

		// directions saturate, radius zero
		set_view(-262144, 262143, 262143, -262144, 262143, 0);
		add_pixel(0, 0);
		add_pixel(4095, 4095);
		add_pixel(1, 1);
		add_pixel(4095, 0);
		drain();
		// centre at origin with zero radius: touching case
		set_view(262143, -262144, -262144, 262143, 0, 0);
		add_pixel(0, 0);
		add_pixel(4095, 4095);
		add_pixel(2, 2);
		drain();
		// huge sphere, straight-down and straight-up rays
		set_view(0, 262143, 0, -128, -262144, 262143);
		add_pixel(0, 0);
		add_pixel(4095, 4095);
		drain();
		set_view(0, 262143, 0, -128, -262144, 1000);
		add_pixel(0, 0);
		add_pixel(0, 4095);
		add_pixel(4095, 2048);
		drain();

		for (int ph = 0; ph < 17; ph++) begin
			bit full;
			full = ($urandom_range(0, 3) == 0);
			set_view(rand_dir(full), rand_dir(full), rand_step(full), rand_step(full),
				-longint'($urandom_range(0, 200000)) + (full ? 131072 : 0),
				full ? $urandom_range(0, 262143) : $urandom_range(0, 90000));
			steady = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < 95; i++) begin
				if ($urandom_range(0, 3) == 0)
					add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
				else
					add_pixel($urandom_range(0, 399), $urandom_range(0, 399));
			end
			drain();
		end
		steady = 0;

		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("[ray_sphere_sky_shader_unit] OK");
		else
			$display("[ray_sphere_sky_shader_unit] ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("[ray_sphere_sky_shader_unit] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
